// ----- rtl/int_to_radix_text_macros.svh -----
// Assertion macros for the radix text converter checker.
`ifndef INT_TO_RADIX_TEXT_MACROS_SVH
`define INT_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define ITRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define ITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/itrt_pkg.sv -----
`timescale 1ns / 1ps

package itrt_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned DIGIT_CAP = 32;
  localparam int unsigned CNT_W     = 6;

  localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [DIGIT_W-1:0] RADIX_DEC = 6'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // Push and pop requests for the digit stack; never both in one cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  // Map a digit value 0..35 to its ASCII glyph.
  function automatic logic [7:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < RADIX_DEC) begin
      glyph = CHAR_ZERO + d8;
    end else begin
      glyph = CHAR_A + (d8 - {2'b00, RADIX_DEC});
    end
  endfunction

endpackage

// ----- rtl/int_to_radix_text.sv -----
`timescale 1ns / 1ps
// Conversion: the shared divider makes one digit per pass (launch, 32 quotient bits,
//   collect), 1..32 digits per value; then one character per cycle is sent while the
//   output is not stalled, a leading '-' first. A new item is taken once the last
//   character has been loaded into the output register. Reset: synchronous, active high;
//   clears the sequencer, the digit count and the output valid. No clearing pass.

module int_to_radix_text (
  input  logic        clk,
  input  logic        rst,
  // Input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] value,
  input  logic [5:0]  base,
  // Character channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last
);

  // Sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;  // wait for an item
  localparam logic [1:0] S_START = 2'd1;  // launch one division
  localparam logic [1:0] S_DIV   = 2'd2;  // wait for quotient and digit
  localparam logic [1:0] S_EMIT  = 2'd3;  // drain sign and digits

  logic [1:0]                        state;
  logic [itrt_pkg::VALUE_W-1:0]      mag;
  logic [itrt_pkg::DIGIT_W-1:0]      radix;
  logic                              minus;

  logic                              in_take;
  logic [itrt_pkg::DIGIT_W-1:0]      radix_sat;
  logic                              neg_in;
  logic [itrt_pkg::VALUE_W-1:0]      mag_in;

  logic                              div_start;
  logic                              div_done;
  logic [itrt_pkg::VALUE_W-1:0]      div_quo;
  logic [itrt_pkg::DIGIT_W-1:0]      div_rem;

  itrt_pkg::stack_ctl_t              stk_ctl;
  logic [itrt_pkg::DIGIT_W-1:0]      stk_top;
  logic [itrt_pkg::CNT_W-1:0]        stk_count;

  logic                              out_free;
  logic                              emit_load;

  // The block takes a new item only when the sequencer is idle; a character
  // still waiting in the output register does not hold it off.
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Clamp the radix into 2..36.
  always_comb begin
    priority if (base < itrt_pkg::RADIX_MIN) begin
      radix_sat = itrt_pkg::RADIX_MIN;
    end else if (base > itrt_pkg::RADIX_MAX) begin
      radix_sat = itrt_pkg::RADIX_MAX;
    end else begin
      radix_sat = base;
    end
  end

  // A minus sign only in signed decimal; negating the most negative value
  // gives 2^31 as an unsigned magnitude, which is what we want.
  assign neg_in = func && (radix_sat == itrt_pkg::RADIX_DEC) &&
                  value[itrt_pkg::VALUE_W-1];
  assign mag_in = neg_in ? (~value + 1'b1) : value;

  // Output register: load when empty or when its item leaves this cycle.
  assign out_free  = !out_valid || !out_stall;
  assign emit_load = (state == S_EMIT) && out_free;

  assign div_start   = (state == S_START);
  assign stk_ctl.push = (state == S_DIV) && div_done;
  assign stk_ctl.pop  = emit_load && !minus;

  itrt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  itrt_digit_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stk_ctl),
    .din   (div_rem),
    .top   (stk_top),
    .count (stk_count)
  );

  // Sequencer. Zero needs no special path: one division yields digit 0 and
  // quotient 0, which ends the loop after a single digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      minus <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            minus <= neg_in;
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= (div_quo == '0) ? S_EMIT : S_START;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            if (minus) begin
              minus <= 1'b0;
            end else if (stk_count == itrt_pkg::CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working magnitude and radix: capture on accept, advance to the quotient.
  always_ff @(posedge clk) begin
    if (in_take) begin
      mag   <= mag_in;
      radix <= radix_sat;
    end else if ((state == S_DIV) && div_done) begin
      mag <= div_quo;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload: the sign goes first, then digits top of stack first.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (minus) begin
        char_out <= itrt_pkg::CHAR_MINUS;
        last     <= 1'b0;
      end else begin
        char_out <= itrt_pkg::glyph(stk_top);
        last     <= (stk_count == itrt_pkg::CNT_W'(1));
      end
    end
  end

endmodule

// ----- rtl/itrt_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module itrt_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [itrt_pkg::VALUE_W-1:0]      dividend,
  input  logic [itrt_pkg::DIGIT_W-1:0]      divisor,
  output logic                              done,
  output logic [itrt_pkg::VALUE_W-1:0]      quotient,
  output logic [itrt_pkg::DIGIT_W-1:0]      remainder
);

  localparam int unsigned STEP_W = $clog2(itrt_pkg::VALUE_W);

  logic                           busy;
  logic [STEP_W-1:0]              step;
  logic [itrt_pkg::VALUE_W-1:0]   quo;
  logic [itrt_pkg::DIGIT_W-1:0]   rem;
  logic [itrt_pkg::DIGIT_W:0]     trial;
  logic [itrt_pkg::DIGIT_W:0]     dvs;
  logic [itrt_pkg::DIGIT_W:0]     diff;
  logic                           fits;

  assign trial = {rem, quo[itrt_pkg::VALUE_W-1]};
  assign dvs   = {1'b0, divisor};
  assign fits  = (trial >= dvs);
  assign diff  = trial - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(itrt_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[itrt_pkg::VALUE_W-2:0], fits};
      rem <= fits ? diff[itrt_pkg::DIGIT_W-1:0] : trial[itrt_pkg::DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- rtl/itrt_digit_stack.sv -----
`timescale 1ns / 1ps

// Last-in first-out digit store: digits arrive least significant first
// and leave most significant first.
module itrt_digit_stack (
  input  logic                           clk,
  input  logic                           rst,
  input  itrt_pkg::stack_ctl_t           ctl,
  input  logic [itrt_pkg::DIGIT_W-1:0]   din,
  output logic [itrt_pkg::DIGIT_W-1:0]   top,
  output logic [itrt_pkg::CNT_W-1:0]     count
);

  logic [itrt_pkg::DIGIT_W-1:0] slot [itrt_pkg::DIGIT_CAP];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + 1'b1;
    end else if (ctl.pop) begin
      count <= count - 1'b1;
    end
  end

  // Shift down on push, up on pop.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slot[0] <= din;
      for (int i = 1; i < itrt_pkg::DIGIT_CAP; i++) begin
        slot[i] <= slot[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < itrt_pkg::DIGIT_CAP - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  assign top = slot[0];

endmodule

// ----- rtl/itrt_checker.sv -----
`timescale 1ns / 1ps
`include "int_to_radix_text_macros.svh"

module itrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_out,
  input logic       last
);

  `ITRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_out) && $stable(last), "stalled character changed")
  `ITRT_ASSERT_NOW(a_char_set, out_valid, (char_out >= itrt_pkg::CHAR_ZERO && char_out <= 8'h39) || (char_out >= itrt_pkg::CHAR_A && char_out <= 8'h7a) || char_out == itrt_pkg::CHAR_MINUS, "character outside digit set")
  `ITRT_ASSERT_NOW(a_sign_not_last, out_valid && char_out == itrt_pkg::CHAR_MINUS, !last, "minus sign marked last")
  `ITRT_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "second item taken while converting")

endmodule

bind int_to_radix_text itrt_checker u_itrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .char_out  (char_out),
  .last      (last)
);
